// ===== hdl/atp_pkg.sv =====
// Shared types, constants and arithmetic helpers for the tilt angle pipeline.
// No dependencies; the top level, atp_prep and atp_cordic refer to it by scoped names.
package atp_pkg;

  localparam int unsigned DataW  = 34;   // CORDIC x/y datapath width
  localparam int unsigned AngW   = 30;   // angle accumulator, degrees * 2^20
  localparam int unsigned TabLen = 24;
  localparam int unsigned InShift = 14;
  localparam int unsigned OutShift = 13;

  localparam logic signed [31:0] GainFix = 32'sd1768195363;  // K * 2^30
  localparam logic signed [AngW-1:0] Deg90Acc = 30'sd94371840;

  localparam logic [14:0] RollLimit  = 15'd23040;
  localparam logic [14:0] PitchLimit = 15'd11520;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [AngW-1:0]  ang_t;

  // atan(2^-i) in degrees * 2^20
  localparam ang_t AtanTab [TabLen] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
    30'sd1876857,  30'sd938658,   30'sd469357,   30'sd234682,  30'sd117342,
    30'sd58671,    30'sd29335,    30'sd14668,    30'sd7334,    30'sd3667,
    30'sd1833,     30'sd917,      30'sd458,      30'sd229,     30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  // Round to 1/128 degree, half away from zero, then clamp to +-limit.
  function automatic logic signed [15:0] to_output(ang_t acc, logic [14:0] limit);
    logic [AngW:0]    mag;
    logic [AngW-OutShift+1:0] q;
    logic [15:0]      qs;
    mag = acc[AngW-1] ? (AngW+1)'(-$signed({acc[AngW-1], acc}))
                      : (AngW+1)'($signed({acc[AngW-1], acc}));
    q = (AngW-OutShift+2)'((mag + (AngW+1)'(1 << (OutShift-1))) >> OutShift);
    if (q > (AngW-OutShift+2)'(limit)) begin
      qs = {1'b0, limit};
    end else begin
      qs = 16'(q);
    end
    return acc[AngW-1] ? -$signed(qs) : $signed(qs);
  endfunction

endpackage

// ===== hdl/accel_tilt_angles.sv =====
// Tilt angle pipeline: roll = atan2(y, z), pitch = atan2(-x, |(y,z)|).
// Depends on atp_pkg, atp_prep and atp_cordic.
//
// Usage:
//   Slave channel s_axis_*: one request per raw accelerometer sample.
//     tdata = accel_x, accel_y, accel_z (16 bits each, lowest first),
//     tuser = read_ok. A request with read_ok low yields two zero angles.
//   Master channel m_axis_*: one result per request, in order.
//     tdata = roll_angle (16 bits), pitch_angle (15 bits), one zero pad bit.
//     Both angles are degrees * 128, signed.
//   Throughput: one request per clock. Every stage can take a new sample
//   each cycle; the whole pipe moves as one when the output register is
//   empty or being drained.
//   Pipeline: one input stage, two CORDIC chains of ITERATIONS+1 stages
//   each (the pitch chain needs the magnitude left by the roll chain),
//   one output rounding register.
//   Reset: asynchronous, active low; clears every valid bit, so the pipe
//   comes up empty. Payload registers are not reset.
//   Stall: while a result waits with m_axis_tready low, the whole pipe
//   holds and s_axis_tready drops; nothing is dropped or repeated.
module accel_tilt_angles #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic        s_axis_tuser_i,   // read_ok
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // roll_angle[15:0], pitch_angle[30:16], zero pad
);

  localparam int unsigned RollSideW  = atp_pkg::DataW + 1;
  localparam int unsigned PitchSideW = atp_pkg::AngW + 1;

  logic                  advance;
  logic                  pre_valid, pre_ok;
  atp_pkg::data_t        pre_nx, pre_y, pre_z;
  logic                  roll_valid;
  atp_pkg::data_t        roll_mag;
  atp_pkg::ang_t         roll_acc;
  logic [RollSideW-1:0]  roll_side;
  logic                  pitch_valid;
  atp_pkg::data_t        pitch_mag;
  atp_pkg::ang_t         pitch_acc;
  logic [PitchSideW-1:0] pitch_side;
  logic                  out_valid_q;
  logic signed [15:0]    roll_q,  roll_d;
  logic signed [14:0]    pitch_q, pitch_d;
  logic signed [15:0]    pitch_full;

  // Advance the whole pipe whenever the output slot is free or being taken.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  atp_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .valid_i   (s_axis_tvalid_i),
    .read_ok_i (s_axis_tuser_i),
    .accel_x_i (s_axis_tdata_i[15:0]),
    .accel_y_i (s_axis_tdata_i[31:16]),
    .accel_z_i (s_axis_tdata_i[47:32]),
    .valid_o   (pre_valid),
    .read_ok_o (pre_ok),
    .nx_o      (pre_nx),
    .y_o       (pre_y),
    .z_o       (pre_z)
  );

  // Roll chain: vector (z, y); carry -x*K and read_ok along.
  atp_cordic #(.ITERATIONS(ITERATIONS), .SIDE_W(RollSideW)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (pre_valid),
    .x_i     (pre_z),
    .y_i     (pre_y),
    .side_i  ({pre_ok, pre_nx}),
    .valid_o (roll_valid),
    .mag_o   (roll_mag),
    .angle_o (roll_acc),
    .side_o  (roll_side)
  );

  // Pitch chain: vector (K*|(y,z)|, -x*K); carry the roll angle and read_ok along.
  atp_cordic #(.ITERATIONS(ITERATIONS), .SIDE_W(PitchSideW)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (roll_valid),
    .x_i     (roll_mag),
    .y_i     (roll_side[atp_pkg::DataW-1:0]),
    .side_i  ({roll_side[atp_pkg::DataW], roll_acc}),
    .valid_o (pitch_valid),
    .mag_o   (pitch_mag),
    .angle_o (pitch_acc),
    .side_o  (pitch_side)
  );

  // Round, clamp and force zero on a failed read.
  assign pitch_full = atp_pkg::to_output(pitch_acc, atp_pkg::PitchLimit);

  always_comb begin
    if (pitch_side[atp_pkg::AngW]) begin
      roll_d  = atp_pkg::to_output(pitch_side[atp_pkg::AngW-1:0], atp_pkg::RollLimit);
      pitch_d = pitch_full[14:0];
    end else begin
      roll_d  = '0;
      pitch_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= pitch_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, pitch_q, roll_q};

  // The final magnitude of the pitch chain is not needed.
  logic unused_mag;
  assign unused_mag = ^pitch_mag;

endmodule

// ===== hdl/atp_prep.sv =====
// Input stage: scales the raw sample into the CORDIC datapath and forms -x*K.
// Depends on atp_pkg.
module atp_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 read_ok_i,
  input  logic signed [15:0]   accel_x_i,
  input  logic signed [15:0]   accel_y_i,
  input  logic signed [15:0]   accel_z_i,
  output logic                 valid_o,
  output logic                 read_ok_o,
  output atp_pkg::data_t       nx_o,
  output atp_pkg::data_t       y_o,
  output atp_pkg::data_t       z_o
);

  logic signed [16:0] neg_x;
  logic signed [48:0] prod;
  logic               valid_q;
  logic               ok_q;
  atp_pkg::data_t     nx_q, y_q, z_q;

  assign neg_x = -$signed({accel_x_i[15], accel_x_i});
  assign prod  = 49'(neg_x) * 49'(atp_pkg::GainFix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= read_ok_i;
      nx_q <= atp_pkg::data_t'(prod >>> (30 - atp_pkg::InShift));
      y_q  <= atp_pkg::data_t'($signed({accel_y_i, {atp_pkg::InShift{1'b0}}}));
      z_q  <= atp_pkg::data_t'($signed({accel_z_i, {atp_pkg::InShift{1'b0}}}));
    end
  end

  assign valid_o   = valid_q;
  assign read_ok_o = ok_q;
  assign nx_o      = nx_q;
  assign y_o       = y_q;
  assign z_o       = z_q;

endmodule

// ===== hdl/atp_cordic.sv =====
// Pipelined vectoring CORDIC: quadrant pre-rotation then one micro-rotation
// per stage. Carries a side payload alongside. Depends on atp_pkg.
module atp_cordic #(
  parameter int unsigned ITERATIONS = 16,
  parameter int unsigned SIDE_W     = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  atp_pkg::data_t       x_i,
  input  atp_pkg::data_t       y_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output atp_pkg::data_t       mag_o,
  output atp_pkg::ang_t        angle_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic              v_q  [ITERATIONS+1];
  logic              zr_q [ITERATIONS+1];
  atp_pkg::data_t    x_q  [ITERATIONS+1];
  atp_pkg::data_t    y_q  [ITERATIONS+1];
  atp_pkg::ang_t     a_q  [ITERATIONS+1];
  logic [SIDE_W-1:0] s_q  [ITERATIONS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  // Turn a vector in the left half-plane by +-90 degrees.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q[0] <= (x_i == '0) && (y_i == '0);
      s_q[0]  <= side_i;
      if (x_i[atp_pkg::DataW-1]) begin
        if (!y_i[atp_pkg::DataW-1]) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          a_q[0] <= atp_pkg::Deg90Acc;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          a_q[0] <= -atp_pkg::Deg90Acc;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    atp_pkg::data_t dx, dy;
    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zr_q[k+1] <= zr_q[k];
        s_q[k+1]  <= s_q[k];
        if (!y_q[k][atp_pkg::DataW-1]) begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          a_q[k+1] <= a_q[k] + atp_pkg::AtanTab[k];
        end else begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          a_q[k+1] <= a_q[k] - atp_pkg::AtanTab[k];
        end
      end
    end
  end

  assign valid_o = v_q[ITERATIONS];
  assign mag_o   = x_q[ITERATIONS];
  assign angle_o = zr_q[ITERATIONS] ? '0 : a_q[ITERATIONS];
  assign side_o  = s_q[ITERATIONS];

endmodule

// ===== hdl/atp_checker.sv =====
// Port-level checks for accel_tilt_angles, attached by the bind below.
// Depends only on the top level's ports.
module atp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // An empty output slot never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[15:0]) <= 16'sd23040) &&
                        ($signed(m_axis_tdata_o[15:0]) >= -16'sd23040))
    else $error("roll out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[30:16]) <= 15'sd11520) &&
                        ($signed(m_axis_tdata_o[30:16]) >= -15'sd11520) &&
                        !m_axis_tdata_o[31])
    else $error("pitch out of range");

endmodule

bind accel_tilt_angles atp_checker u_atp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
